// ----- rtl/qeb_pkg.sv -----
// qeb_pkg: shared constants, cordic arctangent table and step function
// for the quaternion to euler bins pipeline; no dependencies
package qeb_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned CordicWidth = 56;
  localparam logic [6:0] BinCountReset = 7'd18;
  localparam logic signed [33:0] HalfTurn = 34'sh080000000;
  localparam logic signed [33:0] QuarterTurn = 34'sh040000000;
  localparam logic signed [33:0] OneQ30 = 34'sh040000000;

  typedef logic signed [CordicWidth-1:0] cw_t;

  typedef struct packed {
    cw_t x;
    cw_t y;
    logic signed [33:0] z;
  } cordic_t;

  function automatic logic signed [33:0] atan_turns(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0: r = 34'sh20000000;
      5'd1: r = 34'sh12E4051E;
      5'd2: r = 34'sh09FB385B;
      5'd3: r = 34'sh051111D4;
      5'd4: r = 34'sh028B0D43;
      5'd5: r = 34'sh0145D7E1;
      5'd6: r = 34'sh00A2F61E;
      5'd7: r = 34'sh00517C55;
      5'd8: r = 34'sh0028BE53;
      5'd9: r = 34'sh00145F2F;
      5'd10: r = 34'sh000A2F98;
      5'd11: r = 34'sh000517CC;
      5'd12: r = 34'sh00028BE6;
      5'd13: r = 34'sh000145F3;
      5'd14: r = 34'sh0000A2FA;
      5'd15: r = 34'sh0000517D;
      5'd16: r = 34'sh000028BE;
      5'd17: r = 34'sh0000145F;
      5'd18: r = 34'sh00000A30;
      5'd19: r = 34'sh00000518;
      5'd20: r = 34'sh0000028C;
      5'd21: r = 34'sh00000146;
      5'd22: r = 34'sh000000A3;
      5'd23: r = 34'sh00000051;
      5'd24: r = 34'sh00000029;
      5'd25: r = 34'sh00000014;
      5'd26: r = 34'sh0000000A;
      5'd27: r = 34'sh00000005;
      5'd28: r = 34'sh00000003;
      5'd29: r = 34'sh00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic cordic_t cordic_step(input cordic_t a, input logic [4:0] i);
    cordic_t r;
    cw_t dx;
    cw_t dy;
    dx = a.y >>> i;
    dy = a.x >>> i;
    if (a.y > 0) begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + atan_turns(i);
    end else begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - atan_turns(i);
    end
    return r;
  endfunction

endpackage

// ----- rtl/qeb_atan2.sv -----
// qeb_atan2: pipelined atan2 in turns, one cordic iteration per stage
// depends on qeb_pkg
module qeb_atan2 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic signed [33:0] y_i,
  input  logic signed [33:0] x_i,
  output logic signed [33:0] ang_o
);
  localparam int unsigned N = qeb_pkg::CordicSteps;

  qeb_pkg::cordic_t st_q [N+1];
  logic spec_q [N+1];
  logic signed [33:0] spv_q [N+1];

  // stage 0: special cases and half-plane fold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spec_q[0] <= 1'b0;
    end else if (en_i) begin
      spec_q[0] <= (y_i == 0) || (x_i == 0);
      if (y_i == 0) spv_q[0] <= (x_i < 0) ? qeb_pkg::HalfTurn : '0;
      else spv_q[0] <= (y_i > 0) ? qeb_pkg::QuarterTurn : -qeb_pkg::QuarterTurn;
      if (x_i < 0) begin
        st_q[0].x <= (-{{22{x_i[33]}}, x_i}) <<< 20;
        st_q[0].y <= (-{{22{y_i[33]}}, y_i}) <<< 20;
        st_q[0].z <= (y_i > 0) ? qeb_pkg::HalfTurn : -qeb_pkg::HalfTurn;
      end else begin
        st_q[0].x <= {{22{x_i[33]}}, x_i} <<< 20;
        st_q[0].y <= {{22{y_i[33]}}, y_i} <<< 20;
        st_q[0].z <= '0;
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_st
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        spec_q[g+1] <= 1'b0;
      end else if (en_i) begin
        st_q[g+1] <= qeb_pkg::cordic_step(st_q[g], 5'(g));
        spec_q[g+1] <= spec_q[g];
        spv_q[g+1] <= spv_q[g];
      end
    end
  end

  assign ang_o = spec_q[N] ? spv_q[N] : st_q[N].z;
endmodule

// ----- rtl/qeb_isqrt.sv -----
// qeb_isqrt: pipelined 64-bit integer square root, one result bit per stage
// standalone, no package use
module qeb_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [63:0] v_i,
  output logic [31:0] r_o
);
  logic [63:0] v_q [33];
  logic [63:0] r_q [33];
  logic unused;

  assign v_q[0] = v_i;
  assign r_q[0] = '0;

  for (genvar g = 0; g < 32; g++) begin : g_st
    localparam logic [63:0] Bit = 64'd1 << (62 - 2*g);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g+1] <= '0;
        r_q[g+1] <= '0;
      end else if (en_i) begin
        if (v_q[g] >= r_q[g] + Bit) begin
          v_q[g+1] <= v_q[g] - (r_q[g] + Bit);
          r_q[g+1] <= (r_q[g] >> 1) + Bit;
        end else begin
          v_q[g+1] <= v_q[g];
          r_q[g+1] <= r_q[g] >> 1;
        end
      end
    end
  end

  assign unused = ^{v_q[32], r_q[32][63:32]};
  assign r_o = r_q[32][31:0];
endmodule

// ----- rtl/quaternion_to_euler_bins.sv -----
// quaternion_to_euler_bins: top level, quaternion to euler fractions and bins
// depends on qeb_pkg, qeb_atan2, qeb_isqrt
//
// Takes one quaternion item per cycle while the output is not stalled and returns one result item for each.
// The pipe has 1 product stage, 1 argument stage, 1 clamp stage,
// 32 square root stages, 31 cordic stages and 2 output stages.
// The whole pipe advances together when the output is not stalled, so the
// sustained rate is one item per clock; stall_o is simply the output stall.
// bin_count is sampled at the output stage and must only change while idle.
// start_yaw_frac holds the yaw fraction of the first item after reset.
module quaternion_to_euler_bins #(
  parameter int unsigned FRAC_BITS = qeb_pkg::FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [6:0]         cfg_data_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [15:0]        roll_frac_o,
  output logic [15:0]        pitch_frac_o,
  output logic [15:0]        yaw_frac_o,
  output logic [6:0]         roll_bin_o,
  output logic [6:0]         pitch_bin_o,
  output logic [6:0]         yaw_bin_o,
  output logic [15:0]        start_yaw_frac_o
);
  localparam int unsigned SqrtLat = 32;
  localparam int unsigned CordLat = qeb_pkg::CordicSteps + 1;
  localparam int unsigned Lat = 3 + SqrtLat + CordLat + 2;

  logic en;
  assign en = !(valid_o && stall_i);
  assign stall_o = !en;
  assign cfg_ready_o = 1'b1;

  logic [6:0] bin_count_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bin_count_q <= qeb_pkg::BinCountReset;
    else if (cfg_valid_i) bin_count_q <= cfg_data_i;
  end

  // valid shift line alongside the data
  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Lat-2:0], valid_i};
  end

  // stage 1: the nine component products, each exact in 32 bits
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      wz_q <= quat_w_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      wy_q <= quat_w_i * quat_y_i;
      zx_q <= quat_z_i * quat_x_i;
    end
  end

  // stage 2: atan2 arguments in Q30
  logic signed [33:0] rn_q, rd_q, yn_q, yd_q, s_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      rn_q <= 34'(2 * (34'(wx_q) + 34'(yz_q)));
      rd_q <= qeb_pkg::OneQ30 - 34'(2 * (34'(xx_q) + 34'(yy_q)));
      yn_q <= 34'(2 * (34'(wz_q) + 34'(xy_q)));
      yd_q <= qeb_pkg::OneQ30 - 34'(2 * (34'(yy_q) + 34'(zz_q)));
      s_q  <= 34'(2 * (34'(wy_q) - 34'(zx_q)));
    end
  end

  // stage 3: clamp pitch sine and subtract its square from one (31 x 31 bits)
  logic signed [33:0] sc_q, rn3_q, rd3_q, yn3_q, yd3_q;
  logic signed [33:0] sc_d;
  logic [63:0] sq_q;
  always_comb begin
    sc_d = s_q;
    if (s_q > qeb_pkg::OneQ30) sc_d = qeb_pkg::OneQ30;
    if (s_q < -qeb_pkg::OneQ30) sc_d = -qeb_pkg::OneQ30;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_q  <= sc_d;
      sq_q  <= (64'd1 << 60) - 64'(sc_d) * 64'(sc_d);
      rn3_q <= rn_q; rd3_q <= rd_q; yn3_q <= yn_q; yd3_q <= yd_q;
    end
  end

  logic [31:0] c_root;
  qeb_isqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .v_i(sq_q), .r_o(c_root)
  );

  // delay line matching the square root latency
  logic signed [33:0] dl_q [SqrtLat][5];
  for (genvar g = 0; g < SqrtLat; g++) begin : g_dl
    if (g == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (en) begin
          dl_q[0][0] <= sc_q; dl_q[0][1] <= rn3_q; dl_q[0][2] <= rd3_q;
          dl_q[0][3] <= yn3_q; dl_q[0][4] <= yd3_q;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk_i) begin
        if (en) begin
          dl_q[g] <= dl_q[g-1];
        end
      end
    end
  end

  logic signed [33:0] roll_a, pitch_a, yaw_a;
  qeb_atan2 u_roll (.clk_i, .rst_ni, .en_i(en),
    .y_i(dl_q[SqrtLat-1][1]), .x_i(dl_q[SqrtLat-1][2]), .ang_o(roll_a));
  qeb_atan2 u_pitch (.clk_i, .rst_ni, .en_i(en),
    .y_i(dl_q[SqrtLat-1][0]), .x_i({2'b00, c_root}), .ang_o(pitch_a));
  qeb_atan2 u_yaw (.clk_i, .rst_ni, .en_i(en),
    .y_i(dl_q[SqrtLat-1][3]), .x_i(dl_q[SqrtLat-1][4]), .ang_o(yaw_a));

  // offset to saturated fraction, kept at up to 24 bits for the bins
  function automatic logic [23:0] to_frac(input logic signed [34:0] f);
    logic [34:0] v;
    logic [34:0] lim;
    lim = (35'd1 << FRAC_BITS) - 35'd1;
    v = 35'(f) >> (32 - FRAC_BITS);
    if (f < 0) return '0;
    return (v > lim) ? lim[23:0] : v[23:0];
  endfunction

  logic [23:0] rf_q, pf_q, yf_q;
  logic [23:0] rf_d, pf_d, yf_d;
  always_comb begin
    rf_d = to_frac(35'(roll_a) + 35'(qeb_pkg::HalfTurn));
    pf_d = to_frac(35'(2 * (35'(pitch_a) + 35'(qeb_pkg::QuarterTurn))));
    yf_d = to_frac(35'(yaw_a) + 35'(qeb_pkg::HalfTurn));
  end

  // first yaw capture happens as the fraction stage registers its item
  logic taken_q;
  logic [15:0] first_q, first_d;
  assign first_d = taken_q ? first_q : yf_d[15:0];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= 1'b0;
      first_q <= '0;
    end else if (en && vld_q[Lat-3]) begin
      taken_q <= 1'b1;
      first_q <= first_d;
    end
  end

  logic [15:0] fy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      rf_q <= rf_d; pf_q <= pf_d; yf_q <= yf_d; fy_q <= first_d;
    end
  end

  // output stage: bin multiply on the full-width fraction
  function automatic logic [6:0] to_bin(input logic [23:0] f, input logic [6:0] n);
    logic [30:0] p;
    p = 31'(f) * 31'(n);
    return 7'(p >> FRAC_BITS);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_frac_o <= rf_q[15:0]; pitch_frac_o <= pf_q[15:0]; yaw_frac_o <= yf_q[15:0];
      roll_bin_o <= to_bin(rf_q, bin_count_q);
      pitch_bin_o <= to_bin(pf_q, bin_count_q);
      yaw_bin_o <= to_bin(yf_q, bin_count_q);
      start_yaw_frac_o <= fy_q;
    end
  end
  assign valid_o = vld_q[Lat-1];
endmodule

// ----- rtl/qeb_checker.sv -----
// qeb_checker: port-level assertions for quaternion_to_euler_bins
// bound to the top level; no package use
module qeb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_o,
  input logic        stall_i,
  input logic        stall_o,
  input logic [15:0] start_yaw_frac_o,
  input logic [15:0] roll_frac_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(roll_frac_o)) else $error("held item changed");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o == (valid_o && stall_i)) else $error("input stall mismatch");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i ##1 valid_o |-> $stable(start_yaw_frac_o))
    else $error("start yaw changed");
endmodule

bind quaternion_to_euler_bins qeb_checker u_chk (
  .clk_i, .rst_ni, .valid_o, .stall_i, .stall_o,
  .start_yaw_frac_o, .roll_frac_o
);
